@@ design/index_term_run_table_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the index/term run table
// Concurrent checks sampled on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INDEX_TERM_RUN_TABLE_ASSERT_SVH
`define INDEX_TERM_RUN_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/itrt_pkg.sv @@
// ----------------------------------------------------------------------------
// itrt_pkg
// Shared widths, codes, command type and slot arithmetic of the run table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itrt_pkg;

    localparam int RUN_DEPTH = 16;
    localparam int SLOT_W    = $clog2(RUN_DEPTH);
    localparam int CNT_W     = 5;
    localparam int ACT_W     = 3;
    localparam int IDX_W     = 63;
    localparam int TERM_W    = 63;
    localparam int STAT_W    = 2;
    localparam int OP_W      = 3;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [SLOT_W:0]    t_slot_ext;
    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [Q_PTR_W-1:0] t_qptr;
    typedef logic [Q_CNT_W-1:0] t_qcnt;

    localparam t_slot  LAST_SLOT     = t_slot'(RUN_DEPTH - 1);
    localparam t_count RUN_DEPTH_CNT = t_count'(RUN_DEPTH);
    localparam t_qptr  Q_LAST        = t_qptr'(Q_DEPTH - 1);
    localparam t_qcnt  Q_FULL        = t_qcnt'(Q_DEPTH);

    // Request action codes.
    localparam logic [ACT_W-1:0] ACT_LOOKUP       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND       = 3'd1;
    localparam logic [ACT_W-1:0] ACT_TRUNC_PREFIX = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TRUNC_SUFFIX = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RESET        = 3'd4;

    // Internal operation codes after classification.
    localparam logic [OP_W-1:0] OP_LOOKUP       = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND       = 3'd1;
    localparam logic [OP_W-1:0] OP_TRUNC_PREFIX = 3'd2;
    localparam logic [OP_W-1:0] OP_TRUNC_SUFFIX = 3'd3;
    localparam logic [OP_W-1:0] OP_RESET        = 3'd4;
    localparam logic [OP_W-1:0] OP_NOP          = 3'd5;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ORDER = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic [TERM_W-1:0] term;
    } t_cmd;

    function automatic t_slot slot_add(input t_slot base, input t_slot off);
        t_slot_ext sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= t_slot_ext'(RUN_DEPTH)) begin
            sum = sum - t_slot_ext'(RUN_DEPTH);
        end
        return sum[SLOT_W-1:0];
    endfunction

    function automatic t_slot slot_inc(input t_slot s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    function automatic t_slot slot_dec(input t_slot s);
        return (s == '0) ? LAST_SLOT : s - 1'b1;
    endfunction

endpackage

`default_nettype wire

@@ design/itrt_req_if.sv @@
// ----------------------------------------------------------------------------
// itrt_req_if
// Request channel of the run table: action, log index and log term.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface itrt_req_if import itrt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  log_index;
    logic [TERM_W-1:0] log_term;

    modport source (output valid, action, log_index, log_term, input ready);
    modport sink   (input valid, action, log_index, log_term, output ready);
endinterface

`default_nettype wire

@@ design/itrt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// itrt_rsp_if
// Result channel of the run table: found term, status and entry count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface itrt_rsp_if import itrt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TERM_W-1:0] found_term;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  entry_count;

    modport source (output valid, found_term, status, entry_count, input ready);
    modport sink   (input valid, found_term, status, entry_count, output ready);
endinterface

`default_nettype wire

@@ design/itrt_ram.sv @@
// ----------------------------------------------------------------------------
// itrt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ design/itrt_front.sv @@
// ----------------------------------------------------------------------------
// itrt_front
// Accepts requests, maps the action to an operation and queues the commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itrt_front import itrt_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    itrt_req_if.sink   i_req,
    output logic       o_cmd_valid,
    input  wire logic  i_cmd_ready,
    output t_cmd       o_cmd
);

    t_cmd  cmd_in;
    t_cmd  r_q [Q_DEPTH];
    t_qptr r_wptr, n_wptr;
    t_qptr r_rptr, n_rptr;
    t_qcnt r_cnt, n_cnt;
    logic  push, pop;

    // Unused action codes become a no-op that only reports the count.
    always_comb begin
        cmd_in.idx  = i_req.log_index;
        cmd_in.term = i_req.log_term;
        unique case (i_req.action)
            ACT_LOOKUP:       cmd_in.op = OP_LOOKUP;
            ACT_APPEND:       cmd_in.op = OP_APPEND;
            ACT_TRUNC_PREFIX: cmd_in.op = OP_TRUNC_PREFIX;
            ACT_TRUNC_SUFFIX: cmd_in.op = OP_TRUNC_SUFFIX;
            ACT_RESET:        cmd_in.op = OP_RESET;
            default:          cmd_in.op = OP_NOP;
        endcase
    end

    assign i_req.ready = (r_cnt != Q_FULL);
    assign push        = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        if (push) begin
            n_wptr = (r_wptr == Q_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == Q_LAST) ? '0 : r_rptr + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

@@ design/itrt_back.sv @@
// ----------------------------------------------------------------------------
// itrt_back
// Executes queued commands against the run RAMs, one run compare per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itrt_back import itrt_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cmd_valid,
    output logic       o_cmd_ready,
    input  wire t_cmd  i_cmd,
    itrt_rsp_if.source o_rsp
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CMP  = 1'b1;

    logic              r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [TERM_W-1:0] r_term, n_term;
    t_slot             r_oldest, n_oldest;
    t_count            r_count, n_count;
    t_slot             r_slot, n_slot;
    t_count            r_left, n_left;

    logic              r_out_valid, n_out_valid;
    logic [TERM_W-1:0] r_found, n_found;
    logic [STAT_W-1:0] r_status, n_status;
    t_count            r_out_count, n_out_count;

    logic              load;
    logic              we;
    t_slot             waddr;
    t_slot             raddr;
    t_slot             last;
    logic [IDX_W-1:0]  rd_idx;
    logic [TERM_W-1:0] rd_term;

    itrt_ram #(.WIDTH(IDX_W), .DEPTH(RUN_DEPTH)) u_idx_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_state == ST_IDLE ? i_cmd.idx : r_idx),
        .i_raddr (raddr),
        .o_rdata (rd_idx)
    );

    itrt_ram #(.WIDTH(TERM_W), .DEPTH(RUN_DEPTH)) u_term_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_state == ST_IDLE ? i_cmd.term : r_term),
        .i_raddr (raddr),
        .o_rdata (rd_term)
    );

    // A command is taken only when the result register is free by the next edge,
    // so a command that finishes later always finds it empty.
    assign o_cmd_ready = (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign last        = slot_add(r_oldest, t_slot'(r_count - 1'b1));

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_idx       = r_idx;
        n_term      = r_term;
        n_oldest    = r_oldest;
        n_count     = r_count;
        n_slot      = r_slot;
        n_left      = r_left;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_status    = r_status;
        n_out_count = r_out_count;
        load        = 1'b0;
        we          = 1'b0;
        waddr       = r_oldest;
        raddr       = r_slot;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && o_cmd_ready) begin
                    n_op   = i_cmd.op;
                    n_idx  = i_cmd.idx;
                    n_term = i_cmd.term;
                    unique case (i_cmd.op)
                        OP_LOOKUP: begin
                            if (r_count == '0) begin
                                load = 1'b1;
                            end else begin
                                raddr   = last;
                                n_slot  = last;
                                n_left  = r_count;
                                n_state = ST_CMP;
                            end
                        end
                        OP_APPEND: begin
                            if (r_count == '0) begin
                                we      = 1'b1;
                                waddr   = r_oldest;
                                n_count = t_count'(1);
                                load    = 1'b1;
                            end else begin
                                raddr   = last;
                                n_state = ST_CMP;
                            end
                        end
                        OP_TRUNC_PREFIX: begin
                            if (r_count > t_count'(1)) begin
                                raddr   = slot_inc(r_oldest);
                                n_state = ST_CMP;
                            end else begin
                                load = 1'b1;
                            end
                        end
                        OP_TRUNC_SUFFIX: begin
                            if (r_count != '0) begin
                                raddr   = last;
                                n_slot  = last;
                                n_state = ST_CMP;
                            end else begin
                                load = 1'b1;
                            end
                        end
                        OP_RESET: begin
                            n_oldest = '0;
                            n_count  = '0;
                            load     = 1'b1;
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                    if (load) begin
                        n_found  = '0;
                        n_status = STAT_OK;
                    end
                end
            end
            ST_CMP: begin
                n_found  = '0;
                n_status = STAT_OK;
                unique case (r_op)
                    OP_LOOKUP: begin
                        // Walk from the newest run toward the oldest.
                        if (r_idx >= rd_idx) begin
                            n_found = rd_term;
                            load    = 1'b1;
                        end else if (r_left == t_count'(1)) begin
                            load = 1'b1;
                        end else begin
                            n_left = r_left - 1'b1;
                            n_slot = slot_dec(r_slot);
                            raddr  = slot_dec(r_slot);
                        end
                    end
                    OP_APPEND: begin
                        if (r_idx <= rd_idx || r_term < rd_term) begin
                            n_status = STAT_ORDER;
                        end else if (r_term == rd_term) begin
                            n_status = STAT_OK;
                        end else if (r_count == RUN_DEPTH_CNT) begin
                            n_status = STAT_FULL;
                        end else begin
                            we      = 1'b1;
                            waddr   = slot_add(r_oldest, t_slot'(r_count));
                            n_count = r_count + 1'b1;
                        end
                        load = 1'b1;
                    end
                    OP_TRUNC_PREFIX: begin
                        // The data on the read port is the run after the oldest.
                        if (rd_idx <= r_idx) begin
                            n_oldest = slot_inc(r_oldest);
                            n_count  = r_count - 1'b1;
                            if (r_count > t_count'(2)) begin
                                raddr = slot_inc(slot_inc(r_oldest));
                            end else begin
                                load = 1'b1;
                            end
                        end else begin
                            load = 1'b1;
                        end
                    end
                    OP_TRUNC_SUFFIX: begin
                        if (rd_idx > r_idx) begin
                            n_count = r_count - 1'b1;
                            if (r_count > t_count'(1)) begin
                                n_slot = slot_dec(r_slot);
                                raddr  = slot_dec(r_slot);
                            end else begin
                                load = 1'b1;
                            end
                        end else begin
                            load = 1'b1;
                        end
                    end
                    default: begin
                        load = 1'b1;
                    end
                endcase
                if (load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (load) begin
            n_out_valid = 1'b1;
            n_out_count = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_oldest    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_idx       <= n_idx;
        r_term      <= n_term;
        r_slot      <= n_slot;
        r_left      <= n_left;
        r_found     <= n_found;
        r_status    <= n_status;
        r_out_count <= n_out_count;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found_term  = r_found;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_count = r_out_count;

endmodule

`default_nettype wire

@@ design/index_term_run_table.sv @@
// Requests pass through the request queue. Reset, no-op and empty-table requests
// finish straight from idle, appends compare against the newest run, and lookups
// and truncations compare one stored run per cycle on the shared run RAM read
// address. A request is executed only after the last one is done; the queue takes
// new requests meanwhile. Reset (synchronous, active low) empties the table and the
// queue at once; the run RAMs are not cleared since only held runs are ever read.
`timescale 1ns / 1ps
`default_nettype none

`include "index_term_run_table_assert.svh"

// ----------------------------------------------------------------------------
// index_term_run_table
// Ordered table of (first log index, term) runs with lookup, append and trims.
// ----------------------------------------------------------------------------
module index_term_run_table import itrt_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    itrt_req_if.sink   i_req,
    itrt_rsp_if.source o_rsp
);

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    itrt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    itrt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_rsp       (o_rsp)
    );

    `ITRT_ASSERT_NOW(a_count_bound, o_rsp.valid, o_rsp.entry_count <= RUN_DEPTH_CNT,
        "entry count above table depth")
    `ITRT_ASSERT_NOW(a_full_count, o_rsp.valid && o_rsp.status == STAT_FULL,
        o_rsp.entry_count == RUN_DEPTH_CNT, "full status while table not full")
    `ITRT_ASSERT_NOW(a_reject_no_term, o_rsp.valid && o_rsp.status != STAT_OK,
        o_rsp.found_term == '0, "rejected append carries a term")
    `ITRT_ASSERT_NOW(a_no_take_on_stall, cmd_valid && cmd_ready,
        !(o_rsp.valid && !o_rsp.ready), "command taken while result is stalled")
    `ITRT_ASSERT_NEXT(a_take_then_busy, cmd_valid && cmd_ready,
        o_rsp.valid || !cmd_ready, "command taken without result or busy state")

endmodule

`default_nettype wire

@@ tb/sv/tb_index_term_run_table.sv @@
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb_index_term_run_table
// Self-checking bench for the index/term run table. A scoreboard keeps its own
// copy of the run table and predicts each answer in request order. Directed
// corner requests come first, then mostly well-formed random log traffic,
// under several mixes of sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_index_term_run_table;
    import itrt_pkg::*;

    localparam logic [ACT_W-1:0]  ACT_SPARE_FIRST = 3'd5;
    localparam logic [ACT_W-1:0]  ACT_SPARE_LAST  = 3'd7;
    localparam logic [IDX_W-1:0]  IDX_MAX         = '1;
    localparam logic [TERM_W-1:0] TERM_MAX        = '1;
    localparam int RANDOM_REQUESTS = 450;
    localparam int PHASES          = 4;
    localparam int MAX_REPORTS     = 10;
    localparam int TIMEOUT_NS      = 10_000_000;

    typedef struct {
        logic [TERM_W-1:0] found_term;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  entry_count;
    } t_answer;

    class run_table_scoreboard;
        logic [IDX_W-1:0]  first_index [RUN_DEPTH];
        logic [TERM_W-1:0] run_term_of [RUN_DEPTH];
        int unsigned       oldest;
        int unsigned       held;
        t_answer           answers_due[$];
        int unsigned       mismatches;

        function new();
            foreach (first_index[i]) begin
                first_index[i] = '0;
                run_term_of[i] = '0;
            end
            oldest     = 0;
            held       = 0;
            mismatches = 0;
        endfunction

        function int unsigned slot(int unsigned pos);
            return (oldest + pos) % RUN_DEPTH;
        endfunction

        function logic [IDX_W-1:0] newest_index();
            return first_index[slot(held - 1)];
        endfunction

        function logic [TERM_W-1:0] newest_term();
            return run_term_of[slot(held - 1)];
        endfunction

        // Applies one accepted request to the table copy and queues its answer.
        function void note_request(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                                   logic [TERM_W-1:0] term);
            t_answer     ans;
            int unsigned last;
            bit          store;
            bit          hit;
            ans.found_term = '0;
            ans.status     = STAT_OK;
            case (act)
                ACT_LOOKUP: begin
                    hit = 1'b0;
                    for (int k = int'(held) - 1; k >= 0 && !hit; k--) begin
                        if (idx >= first_index[slot(k)]) begin
                            ans.found_term = run_term_of[slot(k)];
                            hit = 1'b1;
                        end
                    end
                end
                ACT_APPEND: begin
                    store = 1'b1;
                    if (held != 0) begin
                        last = slot(held - 1);
                        if (idx <= first_index[last] || term < run_term_of[last]) begin
                            ans.status = STAT_ORDER;
                            store = 1'b0;
                        end else if (term == run_term_of[last]) begin
                            store = 1'b0;
                        end else if (held >= RUN_DEPTH) begin
                            ans.status = STAT_FULL;
                            store = 1'b0;
                        end
                    end
                    if (store) begin
                        first_index[slot(held)] = idx;
                        run_term_of[slot(held)] = term;
                        held++;
                    end
                end
                ACT_TRUNC_PREFIX: begin
                    while (held > 1 && first_index[slot(1)] <= idx) begin
                        oldest = slot(1);
                        held--;
                    end
                end
                ACT_TRUNC_SUFFIX: begin
                    while (held > 0 && first_index[slot(held - 1)] > idx) begin
                        held--;
                    end
                end
                ACT_RESET: begin
                    oldest = 0;
                    held   = 0;
                end
                default: begin
                end
            endcase
            ans.entry_count = CNT_W'(held);
            answers_due.insert(answers_due.size(), ans);
        endfunction

        function void check_answer(logic [TERM_W-1:0] found, logic [STAT_W-1:0] status,
                                   logic [CNT_W-1:0] count);
            t_answer exp_ans;
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: answer with no request pending: term %0d status %0d count %0d",
                             $time, found, status, count);
                end
                return;
            end
            exp_ans = answers_due.pop_front();
            if (exp_ans.found_term !== found || exp_ans.status !== status ||
                exp_ans.entry_count !== count) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: expected term %0d status %0d count %0d, got %0d %0d %0d",
                             $time, exp_ans.found_term, exp_ans.status, exp_ans.entry_count,
                             found, status, count);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    itrt_req_if req ();
    itrt_rsp_if rsp ();

    index_term_run_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    run_table_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [IDX_W-1:0] rand63();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] sat_add(logic [IDX_W-1:0] a, int unsigned b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + b;
        return s[IDX_W] ? IDX_MAX : s[IDX_W-1:0];
    endfunction

    // Mostly an index around the held runs, sometimes anywhere in the range.
    function automatic logic [IDX_W-1:0] pick_boundary();
        logic [63:0] lo;
        logic [63:0] width;
        logic [63:0] r;
        if (sb.held == 0 || $urandom_range(4) == 0) begin
            return rand63() >> $urandom_range(IDX_W - 1);
        end
        lo    = {1'b0, sb.first_index[sb.slot(0)]};
        lo    = (lo > 2) ? lo - 2 : '0;
        width = {1'b0, sb.newest_index()} - lo + 8;
        r     = lo + ({$urandom, $urandom} % width);
        return (r > {1'b0, IDX_MAX}) ? IDX_MAX : r[IDX_W-1:0];
    endfunction

    task automatic send(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                        logic [TERM_W-1:0] term);
        while ($urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid     <= 1'b1;
        req.action    <= act;
        req.log_index <= idx;
        req.log_term  <= term;
        do @(posedge i_clk); while (!req.ready);
        sb.note_request(act, idx, term);
    endtask

    task automatic send_append();
        logic [IDX_W-1:0]  idx;
        logic [TERM_W-1:0] term;
        int                kind;
        kind = $urandom_range(9);
        if (sb.held == 0 || kind == 0) begin
            idx  = $urandom_range(1) ? rand63() >> $urandom_range(IDX_W - 1)
                                     : IDX_W'($urandom_range(40));
            term = $urandom_range(1) ? rand63() >> $urandom_range(TERM_W - 1)
                                     : TERM_W'($urandom_range(5));
        end else if (kind == 1) begin
            // Broken order: a lower term, or an index at or below the newest run.
            idx  = sb.newest_index();
            term = sb.newest_term();
            if (term != 0 && $urandom_range(1) == 1) begin
                idx  = sat_add(idx, $urandom_range(1, 9));
                term = term - 1'b1;
            end else begin
                idx = idx - IDX_W'($urandom_range(idx < 3 ? int'(idx) : 3));
            end
        end else begin
            idx  = sat_add(sb.newest_index(), $urandom_range(1, 20));
            term = ($urandom_range(9) < 3) ? sb.newest_term()
                                           : sat_add(sb.newest_term(), $urandom_range(1, 3));
        end
        send(ACT_APPEND, idx, term);
    endtask

    task automatic send_random(output bit counted);
        int pick;
        pick    = $urandom_range(99);
        counted = 1'b1;
        if (pick < 30) begin
            send(ACT_LOOKUP, pick_boundary(), rand63());
        end else if (pick < 75) begin
            send_append();
        end else if (pick < 84) begin
            send(ACT_TRUNC_PREFIX, pick_boundary(), rand63());
        end else if (pick < 93) begin
            send(ACT_TRUNC_SUFFIX, pick_boundary(), rand63());
        end else if (pick < 97) begin
            send(ACT_RESET, rand63(), rand63());
        end else begin
            send(ACT_W'($urandom_range(int'(ACT_SPARE_FIRST), int'(ACT_SPARE_LAST))),
                 rand63(), rand63());
            counted = 1'b0;
        end
    endtask

    // Result side: check every accepted answer, then pick the next ready.
    initial begin
        rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp.valid && rsp.ready) begin
                sb.check_answer(rsp.found_term, rsp.status, rsp.entry_count);
            end
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int idle_plan  [PHASES] = '{0, 63, 0, 36};
        int stall_plan [PHASES] = '{0, 0, 63, 36};
        int sent;
        bit counted;

        i_rst_n       <= 1'b0;
        req.valid     <= 1'b0;
        req.action    <= ACT_LOOKUP;
        req.log_index <= '0;
        req.log_term  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table: lookups answer zero and trims change nothing.
        send(ACT_LOOKUP, IDX_MAX, TERM_MAX);
        send(ACT_TRUNC_PREFIX, IDX_MAX, '0);
        send(ACT_TRUNC_SUFFIX, '0, '0);
        for (int code = int'(ACT_SPARE_FIRST); code <= int'(ACT_SPARE_LAST); code++) begin
            send(ACT_W'(code), rand63(), rand63());
        end
        send(ACT_APPEND, '0, '0);
        send(ACT_APPEND, '0, TERM_W'(5));        // index not above the newest run
        send(ACT_APPEND, IDX_W'(3), '0);         // same term, nothing stored
        for (int k = 1; k < RUN_DEPTH; k++) begin
            send(ACT_APPEND, IDX_W'(10 * k), TERM_W'(k));
        end
        send(ACT_APPEND, IDX_W'(1000), TERM_W'(100));   // table is full
        send(ACT_APPEND, IDX_W'(2000), TERM_W'(3));     // term below the newest run
        send(ACT_LOOKUP, IDX_W'(25), '0);
        send(ACT_TRUNC_PREFIX, IDX_W'(55), '0);
        send(ACT_TRUNC_SUFFIX, IDX_W'(100), '0);
        send(ACT_LOOKUP, IDX_W'(49), '0);
        send(ACT_TRUNC_PREFIX, IDX_MAX, '0);     // the last run always stays
        send(ACT_APPEND, IDX_MAX, TERM_MAX);
        send(ACT_LOOKUP, IDX_MAX, '0);
        send(ACT_RESET, '0, '0);

        for (int ph = 0; ph < PHASES; ph++) begin
            send_idle_pct  = idle_plan[ph];
            recv_stall_pct = stall_plan[ph];
            sent = 0;
            while (sent < RANDOM_REQUESTS / PHASES) begin
                send_random(counted);
                sent += counted;
            end
            // Hold the request side back until every answer is in.
            req.valid <= 1'b0;
            while (sb.answers_due.size() != 0) @(posedge i_clk);
        end

        repeat (2 * RUN_DEPTH + 8) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/itrt_pkg.sv
design/itrt_req_if.sv
design/itrt_rsp_if.sv
design/itrt_ram.sv
design/itrt_front.sv
design/itrt_back.sv
design/index_term_run_table.sv
tb/sv/tb_index_term_run_table.sv
